// ----- rtl/core/svc_pkg.sv -----
// ----------------------------------------------------------------------------
// svc_pkg
// Shared codes and widths of the sphere volume classifier: query kinds,
// verdicts and configuration register indexes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package svc_pkg;

    localparam int CMD_W     = 2;
    localparam int VERDICT_W = 2;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_POINT  = 2'd0,
        CMD_BOX    = 2'd1,
        CMD_SPHERE = 2'd2
    } t_cmd;

    typedef enum logic [VERDICT_W-1:0] {
        V_OUTSIDE      = 2'd0,
        V_INSIDE       = 2'd1,
        V_INTERMEDIATE = 2'd2
    } t_verdict;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CENTER_X = 2'd0,
        CFG_CENTER_Y = 2'd1,
        CFG_CENTER_Z = 2'd2,
        CFG_RADIUS   = 2'd3
    } t_cfg_idx;

endpackage

`default_nettype wire

// ----- rtl/core/svc_query_if.sv -----
// ----------------------------------------------------------------------------
// svc_query_if
// Query channel: valid/ready handshake with command, position, box maximum
// and query radius.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface svc_query_if #(
    parameter int COORD_WIDTH = 16
);
    import svc_pkg::*;

    logic                          valid;
    logic                          ready;
    logic [CMD_W-1:0]              cmd;
    logic signed [COORD_WIDTH-1:0] pos_x;
    logic signed [COORD_WIDTH-1:0] pos_y;
    logic signed [COORD_WIDTH-1:0] pos_z;
    logic signed [COORD_WIDTH-1:0] max_x;
    logic signed [COORD_WIDTH-1:0] max_y;
    logic signed [COORD_WIDTH-1:0] max_z;
    logic [COORD_WIDTH-2:0]        query_radius;

    modport source (
        output valid, cmd, pos_x, pos_y, pos_z, max_x, max_y, max_z, query_radius,
        input  ready
    );

    modport sink (
        input  valid, cmd, pos_x, pos_y, pos_z, max_x, max_y, max_z, query_radius,
        output ready
    );

endinterface

`default_nettype wire

// ----- rtl/core/svc_verdict_if.sv -----
// ----------------------------------------------------------------------------
// svc_verdict_if
// Result channel: valid/ready handshake carrying one verdict per beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface svc_verdict_if;
    import svc_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [VERDICT_W-1:0] verdict;

    modport source (
        output valid, verdict,
        input  ready
    );

    modport sink (
        input  valid, verdict,
        output ready
    );

endinterface

`default_nettype wire

// ----- rtl/core/svc_axis.sv -----
// ----------------------------------------------------------------------------
// svc_axis
// One axis of the classifier: squared distances of the low and high
// coordinates from the centre, and the bounding cube miss flag, registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module svc_axis #(
    parameter int COORD_WIDTH = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_en,
    input  wire logic signed [COORD_WIDTH-1:0] i_lo,
    input  wire logic signed [COORD_WIDTH-1:0] i_hi,
    input  wire logic signed [COORD_WIDTH-1:0] i_center,
    input  wire logic [COORD_WIDTH-2:0]        i_radius,
    output logic [2*COORD_WIDTH+1:0]           o_lo_sq,
    output logic [2*COORD_WIDTH+1:0]           o_hi_sq,
    output logic                               o_miss
);

    localparam int DW   = COORD_WIDTH + 1;
    localparam int SQ_W = 2 * COORD_WIDTH + 2;

    logic signed [DW-1:0] w_c;
    logic signed [DW-1:0] w_r;
    logic signed [DW-1:0] w_dlo;
    logic signed [DW-1:0] w_dhi;
    logic [DW-1:0]        w_mlo;
    logic [DW-1:0]        w_mhi;
    logic                 w_miss;

    logic [SQ_W-1:0] r_lo_sq;
    logic [SQ_W-1:0] r_hi_sq;
    logic            r_miss;

    assign w_c   = DW'(i_center);
    assign w_r   = $signed(DW'(i_radius));
    assign w_dlo = DW'(i_lo) - w_c;
    assign w_dhi = DW'(i_hi) - w_c;
    assign w_mlo = w_dlo[DW-1] ? DW'(-w_dlo) : DW'(w_dlo);
    assign w_mhi = w_dhi[DW-1] ? DW'(-w_dhi) : DW'(w_dhi);
    assign w_miss = ((w_c + w_r) < DW'(i_lo)) || ((w_c - w_r) > DW'(i_hi));

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lo_sq <= SQ_W'(w_mlo) * SQ_W'(w_mlo);
            r_hi_sq <= SQ_W'(w_mhi) * SQ_W'(w_mhi);
            r_miss  <= w_miss;
        end
    end

    assign o_lo_sq = r_lo_sq;
    assign o_hi_sq = r_hi_sq;
    assign o_miss  = r_miss;

endmodule

`default_nettype wire

// ----- rtl/core/sphere_volume_classifier.sv -----
// ----------------------------------------------------------------------------
// sphere_volume_classifier
// Classifies point, box and sphere queries against a configured sphere as
// outside, inside or intermediate, with exact fixed-point comparisons.
// ----------------------------------------------------------------------------
// Pipeline: three register stages (input, squares, verdict); a verdict is
//   offered from the verdict stage once its query has passed the input and squares stages.
// Throughput: one query per cycle while verdicts are taken; the
//   whole pipeline holds while a verdict waits to be taken.
// Reset: clears all stage valids and the sphere centre and radius to zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sphere_volume_classifier #(
    parameter int COORD_WIDTH = 16
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [svc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [COORD_WIDTH-1:0]      i_cfg_data,
    svc_query_if.sink                        i_query,
    svc_verdict_if.source                    o_result
);
    import svc_pkg::*;

    localparam int CW   = COORD_WIDTH;
    localparam int RW   = COORD_WIDTH - 1;
    localparam int SQ_W = 2 * COORD_WIDTH + 2;
    localparam int D2_W = SQ_W + 2;

    // configuration
    logic signed [CW-1:0] r_cx;
    logic signed [CW-1:0] r_cy;
    logic signed [CW-1:0] r_cz;
    logic [RW-1:0]        r_radius;

    // stage control
    logic w_en;
    logic r1_v;
    logic r2_v;
    logic r3_v;

    // stage 1: input register
    logic [CMD_W-1:0]     r1_cmd;
    logic signed [CW-1:0] r1_lo [3];
    logic signed [CW-1:0] r1_hi [3];
    logic [RW-1:0]        r1_qr;

    // stage 2: squares
    logic [SQ_W-1:0]     w_lo_sq [3];
    logic [SQ_W-1:0]     w_hi_sq [3];
    logic [2:0]          w_miss;
    logic [CMD_W-1:0]    r2_cmd;
    logic [2*RW-1:0]     r2_rsq;
    logic [2*CW-1:0]     r2_outer_sq;
    logic [2*RW-1:0]     r2_inner_sq;
    logic                r2_r_ge;
    logic [CW-1:0]       w_outer;
    logic [RW-1:0]       w_inner;

    // stage 3: verdict
    logic [D2_W-1:0] w_corner [8];
    logic [7:0]      w_corner_in;
    logic [D2_W-1:0] w_d2;
    t_verdict        n_verdict;
    t_verdict        r3_verdict;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx     <= '0;
            r_cy     <= '0;
            r_cz     <= '0;
            r_radius <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_CENTER_X: r_cx     <= i_cfg_data;
                CFG_CENTER_Y: r_cy     <= i_cfg_data;
                CFG_CENTER_Z: r_cz     <= i_cfg_data;
                CFG_RADIUS:   r_radius <= i_cfg_data[RW-1:0];
            endcase
        end
    end

    // advance every stage unless a verdict is held
    assign w_en          = !r3_v || o_result.ready;
    assign i_query.ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
        end else if (w_en) begin
            r1_v <= i_query.valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_cmd   <= i_query.cmd;
            r1_lo[0] <= i_query.pos_x;
            r1_lo[1] <= i_query.pos_y;
            r1_lo[2] <= i_query.pos_z;
            r1_hi[0] <= i_query.max_x;
            r1_hi[1] <= i_query.max_y;
            r1_hi[2] <= i_query.max_z;
            r1_qr    <= i_query.query_radius;
        end
    end

    svc_axis #(.COORD_WIDTH(CW)) u_axis_x (
        .i_clk    (i_clk),
        .i_en     (w_en),
        .i_lo     (r1_lo[0]),
        .i_hi     (r1_hi[0]),
        .i_center (r_cx),
        .i_radius (r_radius),
        .o_lo_sq  (w_lo_sq[0]),
        .o_hi_sq  (w_hi_sq[0]),
        .o_miss   (w_miss[0])
    );

    svc_axis #(.COORD_WIDTH(CW)) u_axis_y (
        .i_clk    (i_clk),
        .i_en     (w_en),
        .i_lo     (r1_lo[1]),
        .i_hi     (r1_hi[1]),
        .i_center (r_cy),
        .i_radius (r_radius),
        .o_lo_sq  (w_lo_sq[1]),
        .o_hi_sq  (w_hi_sq[1]),
        .o_miss   (w_miss[1])
    );

    svc_axis #(.COORD_WIDTH(CW)) u_axis_z (
        .i_clk    (i_clk),
        .i_en     (w_en),
        .i_lo     (r1_lo[2]),
        .i_hi     (r1_hi[2]),
        .i_center (r_cz),
        .i_radius (r_radius),
        .o_lo_sq  (w_lo_sq[2]),
        .o_hi_sq  (w_hi_sq[2]),
        .o_miss   (w_miss[2])
    );

    assign w_outer = CW'(r_radius) + CW'(r1_qr);
    assign w_inner = r_radius - r1_qr;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_cmd      <= r1_cmd;
            r2_rsq      <= (2*RW)'(r_radius) * (2*RW)'(r_radius);
            r2_outer_sq <= (2*CW)'(w_outer) * (2*CW)'(w_outer);
            r2_inner_sq <= (2*RW)'(w_inner) * (2*RW)'(w_inner);
            r2_r_ge     <= r_radius >= r1_qr;
        end
    end

    for (genvar i = 0; i < 8; i++) begin : g_corner
        assign w_corner[i] = D2_W'(((i % 2) == 1) ? w_hi_sq[0] : w_lo_sq[0])
                           + D2_W'((((i / 2) % 2) == 1) ? w_hi_sq[1] : w_lo_sq[1])
                           + D2_W'(((i / 4) == 1) ? w_hi_sq[2] : w_lo_sq[2]);
        assign w_corner_in[i] = w_corner[i] <= D2_W'(r2_rsq);
    end

    assign w_d2 = w_corner[0];

    always_comb begin
        n_verdict = V_OUTSIDE;
        unique case (t_cmd'(r2_cmd))
            CMD_POINT: begin
                n_verdict = w_corner_in[0] ? V_INSIDE : V_OUTSIDE;
            end
            CMD_BOX: begin
                if (|w_miss) begin
                    n_verdict = V_OUTSIDE;
                end else if (&w_corner_in) begin
                    n_verdict = V_INSIDE;
                end else begin
                    n_verdict = V_INTERMEDIATE;
                end
            end
            CMD_SPHERE: begin
                if (w_d2 > D2_W'(r2_outer_sq)) begin
                    n_verdict = V_OUTSIDE;
                end else if (r2_r_ge && (w_d2 <= D2_W'(r2_inner_sq))) begin
                    n_verdict = V_INSIDE;
                end else begin
                    n_verdict = V_INTERMEDIATE;
                end
            end
            default: n_verdict = V_OUTSIDE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_verdict <= n_verdict;
        end
    end

    assign o_result.valid   = r3_v;
    assign o_result.verdict = r3_verdict;

endmodule

`default_nettype wire
